// ===== hdl/lsms_pkg.sv =====
package lsms_pkg;

    localparam int LSMS_QDEPTH = 2;

    // Request kinds, taken from the two bits on the input tuser.
    localparam logic [1:0] KIND_LOAD       = 2'd0;
    localparam logic [1:0] KIND_STORE      = 2'd1;
    localparam logic [1:0] KIND_LOAD_ALT   = 2'd2;
    localparam logic [1:0] KIND_STORE_ALT  = 2'd3;

    // Mode bit positions.
    localparam int MODE_AFTER  = 4;
    localparam int MODE_DEC    = 3;
    localparam int MODE_MODIFY = 2;

    typedef enum logic [1:0] {
        F_IDLE,
        F_COUNT,
        F_CALC
    } t_front_state;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } t_back_state;

    // One classified instruction, as it waits between front and back.
    typedef struct packed {
        logic [31:0] mask;        // register set, already in walk order
        logic [31:0] start_addr;
        logic [31:0] final_base;
        logic        alt;
        logic        store;
        logic        modify;
        logic        err;
    } t_lsms_cmd;

    typedef struct packed {
        logic        access_valid;
        logic        is_store;
        logic [4:0]  reg_index;
        logic [31:0] address;
        logic        writeback_enable;
        logic [31:0] new_base;
        logic        error_flag;
        logic        last_item;
    } t_lsms_result;

    // In alternate order the top four walk slots hold r31, r29, r30, r28.
    // The mapping is its own inverse, so it serves both directions.
    function automatic logic [4:0] lsms_alt_reg(input logic [4:0] pos, input logic alt);
        logic [4:0] r;
        r = pos;
        if (alt) begin
            if (pos == 5'd28) begin
                r = 5'd31;
            end else if (pos == 5'd31) begin
                r = 5'd28;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] lsms_to_walk_order(input logic [31:0] mask,
                                                       input logic alt);
        logic [31:0] w;
        w = mask;
        if (alt) begin
            w[28] = mask[31];
            w[31] = mask[28];
        end
        return w;
    endfunction

    function automatic logic [5:0] lsms_popcount(input logic [31:0] v);
        logic [5:0] c;
        c = '0;
        for (int i = 0; i < 32; i++) begin
            c = c + 6'(v[i]);
        end
        return c;
    endfunction

endpackage

// ===== hdl/lsms_front.sv =====
module lsms_front
    import lsms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [4:0]  i_first_reg,
    input  logic [4:0]  i_end_reg,
    input  logic [3:0]  i_extra_mask,
    input  logic [4:0]  i_mode_bits,
    input  logic [31:0] i_base_value,
    output logic        o_push_valid,
    input  logic        i_push_ready,
    output t_lsms_cmd   o_push_cmd
);

    t_front_state r_state, n_state;
    logic [31:0]  r_mask;
    logic [1:0]   r_kind;
    logic         r_after, r_dec, r_modify;
    logic [31:0]  r_base;
    logic [5:0]   r_count;

    logic [31:0] w_mask;
    logic        w_accept;
    logic [31:0] w_step4;
    logic [31:0] w_final;
    logic [31:0] w_start;
    logic        w_alt, w_store, w_err;

    assign w_accept = i_valid && o_ready;

    // Range bits plus the extra r28..r31 bits; "both 31" means no range.
    always_comb begin
        for (int i = 0; i < 32; i++) begin
            w_mask[i] = (5'(i) >= i_first_reg) && (5'(i) <= i_end_reg) &&
                        !((i_first_reg == 5'd31) && (i_end_reg == 5'd31));
        end
        w_mask[31] = w_mask[31] | i_extra_mask[0];
        w_mask[30] = w_mask[30] | i_extra_mask[1];
        w_mask[29] = w_mask[29] | i_extra_mask[2];
        w_mask[28] = w_mask[28] | i_extra_mask[3];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  begin
                if (i_valid) begin
                    n_state = F_COUNT;
                end
            end
            F_COUNT: n_state = F_CALC;
            F_CALC:  begin
                if (i_push_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_ready      = (r_state == F_IDLE);
        o_push_valid = (r_state == F_CALC);
    end

    always_comb begin
        w_alt   = (r_kind == KIND_LOAD_ALT) || (r_kind == KIND_STORE_ALT);
        w_store = (r_kind == KIND_STORE) || (r_kind == KIND_STORE_ALT);
        w_err   = (r_kind == KIND_STORE_ALT) && r_mask[31];
        w_step4 = {24'd0, r_count, 2'b00};
        w_final = r_dec ? (r_base - w_step4) : (r_base + w_step4);
        if (r_dec) begin
            w_start = r_after ? w_final : (w_final + 32'd4);
        end else begin
            w_start = r_after ? (r_base + 32'd4) : r_base;
        end

        o_push_cmd.mask       = w_err ? '0 : lsms_to_walk_order(r_mask, w_alt);
        o_push_cmd.start_addr = w_start;
        o_push_cmd.final_base = w_err ? r_base : w_final;
        o_push_cmd.alt        = w_alt;
        o_push_cmd.store      = w_store;
        o_push_cmd.modify     = r_modify && !w_err;
        o_push_cmd.err        = w_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mask   <= w_mask;
            r_kind   <= i_req_type;
            r_after  <= i_mode_bits[MODE_AFTER];
            r_dec    <= i_mode_bits[MODE_DEC];
            r_modify <= i_mode_bits[MODE_MODIFY];
            r_base   <= i_base_value;
        end
        if (r_state == F_COUNT) begin
            r_count <= lsms_popcount(r_mask);
        end
    end

endmodule

// ===== hdl/lsms_queue.sv =====
module lsms_queue
    import lsms_pkg::*;
#(
    parameter int DEPTH = LSMS_QDEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push_valid,
    output logic      o_push_ready,
    input  t_lsms_cmd i_push_cmd,
    output logic      o_pop_valid,
    input  logic      i_pop_ready,
    output t_lsms_cmd o_pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_lsms_cmd        r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_slots[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slots[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ===== hdl/lsms_back.sv =====
module lsms_back
    import lsms_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_pop_valid,
    output logic         o_pop_ready,
    input  t_lsms_cmd    i_pop_cmd,
    output logic         o_valid,
    input  logic         i_ready,
    output t_lsms_result o_result
);

    t_back_state  r_state, n_state;
    t_lsms_cmd    r_cmd;
    logic [31:0]  r_addr;
    logic         r_out_valid;
    t_lsms_result r_out;

    logic         w_slot;
    logic         w_emit;
    logic [4:0]   w_pos;
    logic [31:0]  w_rest;
    logic         w_special;
    t_lsms_result w_res;

    assign w_slot = !r_out_valid || i_ready;
    assign w_emit = (r_state == B_RUN) && w_slot;

    // Lowest pending slot in walk order.
    always_comb begin
        w_pos = '0;
        for (int i = 31; i >= 0; i--) begin
            if (r_cmd.mask[i]) begin
                w_pos = 5'(i);
            end
        end
    end

    always_comb begin
        w_rest    = r_cmd.mask & (r_cmd.mask - 32'd1);
        w_special = r_cmd.err || (r_cmd.mask == '0);

        w_res.access_valid     = !w_special;
        w_res.is_store         = r_cmd.store;
        w_res.reg_index        = w_special ? 5'd0 : lsms_alt_reg(w_pos, r_cmd.alt);
        w_res.address          = w_special ? 32'd0 : r_addr;
        w_res.last_item        = w_special || (w_rest == '0);
        w_res.writeback_enable = w_res.last_item && r_cmd.modify;
        w_res.new_base         = w_res.last_item ? r_cmd.final_base : 32'd0;
        w_res.error_flag       = r_cmd.err;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_pop_valid) begin
                    n_state = B_RUN;
                end
            end
            B_RUN: begin
                if (w_emit && w_res.last_item) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop_ready = (r_state == B_IDLE);
        o_valid     = r_out_valid;
        o_result    = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == B_IDLE) && i_pop_valid) begin
            r_cmd  <= i_pop_cmd;
            r_addr <= i_pop_cmd.start_addr;
        end else if (w_emit) begin
            r_cmd.mask <= w_rest;
            r_addr     <= r_addr + 32'd4;
        end
        if (w_emit) begin
            r_out <= w_res;
        end
    end

endmodule

// ===== hdl/load_store_multiple_sequencer.sv =====
// Load/store-multiple address sequencer. Each input request describes one
// load-multiple or store-multiple instruction; the block answers with one
// result per register in the set, in ascending word-address order, and the
// last result (tlast) carries the written-back base. An empty set gives a
// single result with no access, and a store-alternate request that lists r31
// gives a single error result. The front end classifies a request through
// capture and register-set build, population count and address arithmetic
// and hands it to a small queue; the back end then takes the request from
// the queue and produces one result per cycle while every result is taken
// at once. The front end takes a new request only once it has pushed the
// last one into the queue, and waits while the queue is full, so it can
// classify the next instruction while the back end is still walking the
// previous one. Results sit in an output register: the back end moves on
// to the next result in the same cycle that the waiting one is taken, and
// stalls for as long as the waiting result is held off.
module load_store_multiple_sequencer
    import lsms_pkg::*;
#(
    parameter int QUEUE_DEPTH = LSMS_QDEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // Fields from bit 0: first_reg[4:0], end_reg[9:5], extra_mask[13:10],
    // mode_bits[18:14], base_value[50:19], zero fill up to bit 55.
    input  logic [55:0] i_s_tdata,
    // Fields from bit 0: req_type[1:0].
    input  logic [1:0]  i_s_tuser,
    // Result channel.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // Fields from bit 0: reg_index[4:0], address[36:5], writeback_enable[37],
    // new_base[69:38], zero fill up to bit 71.
    output logic [71:0] o_m_tdata,
    // Fields from bit 0: access_valid[0], is_store[1], error_flag[2].
    output logic [2:0]  o_m_tuser,
    // last_item.
    output logic        o_m_tlast
);

    logic         w_push_valid, w_push_ready;
    t_lsms_cmd    w_push_cmd;
    logic         w_pop_valid, w_pop_ready;
    t_lsms_cmd    w_pop_cmd;
    t_lsms_result w_result;

    // Front end: builds the register set, counts it and works out the start
    // address and the written-back base.
    lsms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_req_type   (i_s_tuser),
        .i_first_reg  (i_s_tdata[4:0]),
        .i_end_reg    (i_s_tdata[9:5]),
        .i_extra_mask (i_s_tdata[13:10]),
        .i_mode_bits  (i_s_tdata[18:14]),
        .i_base_value (i_s_tdata[50:19]),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_cmd   (w_push_cmd)
    );

    // Decouples classification from sequencing.
    lsms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_cmd   (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_cmd    (w_pop_cmd)
    );

    // Back end: one register per unstalled cycle, lowest walk slot first.
    lsms_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_cmd   (w_pop_cmd),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_result    (w_result)
    );

    assign o_m_tdata = {2'b00, w_result.new_base, w_result.writeback_enable,
                        w_result.address, w_result.reg_index};
    assign o_m_tuser = {w_result.error_flag, w_result.is_store, w_result.access_valid};
    assign o_m_tlast = w_result.last_item;

endmodule
